// ----- hw/rtl/tcw_pkg.sv -----
// shared types and constants of the text console character writer
package tcw_pkg;

	// screen geometry defaults
	localparam int unsigned DEF_COLUMNS = 80;
	localparam int unsigned DEF_ROWS    = 25;

	// field widths
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned INDEX_W = 11;
	localparam int unsigned POS_W   = 11;
	localparam int unsigned CELL_W  = 16;
	localparam int unsigned COLOR_W = 4;
	localparam int unsigned CFG_INDEX_W = 1;

	// stream payload widths, padded to whole bytes
	localparam int unsigned IN_DATA_W  = ((CHAR_W + INDEX_W + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W = ((POS_W + CELL_W + 1 + 7) / 8) * 8;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// tab stops every eight columns
	localparam int unsigned TAB_STEP = 8;
	localparam int unsigned TAB_MASK = 7;

	// color reset values and the power-up cell
	localparam logic [COLOR_W-1:0] FG_RESET  = 4'h7;
	localparam logic [COLOR_W-1:0] BG_RESET  = 4'h0;
	localparam logic [CELL_W-1:0]  INIT_CELL = 16'h0720;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_FG = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BG = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_FILL,
		ST_READ,
		ST_READ_DATA,
		ST_DONE
	} state_t;

endpackage

// ----- hw/rtl/tcw_screen_ram.sv -----
// screen cell memory with one write port and one registered read port
module tcw_screen_ram import tcw_pkg::*; #(
	parameter int unsigned DEPTH = DEF_COLUMNS * DEF_ROWS,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/text_console_character_writer_unit.sv -----
// text console character writer: top level with cursor sequencer and screen memory
//
// A character-cell console of ROWS x COLUMNS 16-bit cells (attribute in the high
// byte, character in the low byte) with a cursor. Each transfer on the s_ side is
// one item: put a character (newline, carriage return, backspace and tab are
// interpreted), clear the screen, or read one cell. Each item gives exactly one
// transfer on the m_ side with the linear cursor position, the read cell (zero
// unless a read item hits the screen) and a scroll flag. Items are handled one at
// a time by a small sequencer around a single-port-write, single-port-read cell
// memory; one address counter and adder sweeps the memory for scroll and clear.
// A put that scrolls moves each cell up one row with a read then a write through
// the memory ports. s_tready returns in the same cycle as m_tvalid rises, and
// stays low while a finished result cannot be moved into the output register.
// After reset a clearing pass writes the power-up cell into memory; s_tready is
// low during it while configuration writes are taken as always. cfg_ready is
// always high.
module text_console_character_writer_unit import tcw_pkg::*; #(
	parameter int unsigned COLUMNS = DEF_COLUMNS,
	parameter int unsigned ROWS    = DEF_ROWS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // char_code, cell_index, zero pad
	input  logic [KIND_W-1:0]      s_tuser,   // kind
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // cursor_position, cell_data, scrolled, zero pad
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]     cfg_data
);

	localparam int unsigned CELLS = COLUMNS * ROWS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned CW    = $clog2(COLUMNS);
	localparam int unsigned RW    = $clog2(ROWS);
	// one spare bit so a column or row can run past the edge before wrapping
	localparam int unsigned NCW   = CW + 1;
	localparam int unsigned NRW   = RW + 1;

	// sequencer and cursor
	state_t              state_q, state_d;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic [AW-1:0]       p_q;        // sweep address for scroll, clear and init
	logic [COLOR_W-1:0]  fg_q, bg_q;
	logic                m_tvalid_q;

	// item payload
	logic [CHAR_W-1:0]   char_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [CELL_W-1:0]   fill_q;     // blank cell taken at the start of the item
	logic [CELL_W-1:0]   cell_q;
	logic                scrolled_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// memory ports
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [CELL_W-1:0]   ram_wdata, ram_rdata;

	// derived values
	logic [CHAR_W-1:0]   attr;
	logic [CELL_W-1:0]   blank;
	logic [AW-1:0]       cur_lin;
	logic                idx_ok;
	logic                s_xfer, out_free;
	logic [KIND_W-1:0]   in_kind;

	// put decode
	logic [NCW-1:0]      ncol;
	logic [NRW-1:0]      nrow;
	logic                put_we;
	logic [AW-1:0]       put_addr;
	logic [CELL_W-1:0]   put_data;
	logic                need_scroll;

	assign attr     = {bg_q, fg_q};
	assign blank    = {attr, CH_SPACE};
	assign cur_lin  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign idx_ok   = 32'(idx_q) < CELLS;
	assign in_kind  = s_tuser;
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

	// put character: new cursor and the cell it writes, from the current cursor
	always_comb begin
		ncol     = NCW'(col_q);
		nrow     = NRW'(row_q);
		put_we   = 1'b0;
		put_addr = cur_lin;
		put_data = {attr, char_q};
		unique case (char_q)
			CH_LF: begin
				ncol = '0;
				nrow = nrow + 1'b1;
			end
			CH_CR: begin
				ncol = '0;
			end
			CH_BS: begin
				// backspace at column zero leaves everything alone
				if (col_q != '0) begin
					ncol     = ncol - 1'b1;
					put_we   = 1'b1;
					put_addr = cur_lin - 1'b1;
					put_data = blank;
				end
			end
			CH_TAB: begin
				ncol = (ncol + NCW'(TAB_STEP)) & ~NCW'(TAB_MASK);
			end
			default: begin
				put_we = 1'b1;
				ncol   = ncol + 1'b1;
			end
		endcase
		// column overflow wraps to the next row
		if (ncol >= NCW'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + 1'b1;
		end
		need_scroll = nrow >= NRW'(ROWS);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (p_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_kind)
						KIND_PUT:   state_d = ST_EXEC;
						KIND_CLEAR: state_d = ST_FILL;
						KIND_READ:  state_d = ST_READ;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_EXEC: begin
				state_d = need_scroll ? ST_SCROLL_RD : ST_DONE;
			end
			ST_SCROLL_RD: begin
				state_d = ST_SCROLL_WR;
			end
			ST_SCROLL_WR: begin
				// last row moved up: blank the bottom row
				state_d = (p_q == AW'(CELLS - COLUMNS - 1)) ? ST_FILL : ST_SCROLL_RD;
			end
			ST_FILL: begin
				if (p_q == AW'(CELLS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_READ_DATA;
			end
			ST_READ_DATA: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory controls and input handshake
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = fill_q;
		ram_re    = 1'b0;
		ram_raddr = AW'(idx_q);
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = INIT_CELL;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_EXEC: begin
				ram_we    = put_we;
				ram_waddr = put_addr;
				ram_wdata = put_data;
			end
			ST_SCROLL_RD: begin
				// fetch the cell one row below
				ram_re    = 1'b1;
				ram_raddr = p_q + AW'(COLUMNS);
			end
			ST_SCROLL_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_READ: begin
				ram_re = idx_ok;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			row_q      <= '0;
			col_q      <= '0;
			p_q        <= '0;
			fg_q       <= FG_RESET;
			bg_q       <= BG_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_FG: fg_q <= cfg_data;
					CFG_BG: bg_q <= cfg_data;
				endcase
			end

			unique case (state_q)
				ST_INIT, ST_FILL, ST_SCROLL_WR: begin
					// sweep address wraps to zero at the end of the init or fill pass
					p_q <= (p_q == AW'(CELLS - 1)) ? '0 : p_q + 1'b1;
				end
				ST_IDLE: begin
					p_q <= '0;
					if (s_xfer && in_kind == KIND_CLEAR) begin
						row_q <= '0;
						col_q <= '0;
					end
				end
				ST_EXEC: begin
					col_q <= ncol[CW-1:0];
					row_q <= need_scroll ? RW'(ROWS - 1) : nrow[RW-1:0];
				end
				default: begin
				end
			endcase

			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			char_q     <= s_tdata[CHAR_W-1:0];
			idx_q      <= s_tdata[CHAR_W+INDEX_W-1:CHAR_W];
			fill_q     <= blank;
			cell_q     <= '0;
			scrolled_q <= 1'b0;
		end
		if (state_q == ST_EXEC) begin
			scrolled_q <= need_scroll;
		end
		if (state_q == ST_READ_DATA) begin
			// reads beyond the screen give zero
			cell_q <= idx_ok ? ram_rdata : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= OUT_DATA_W'({scrolled_q, cell_q, POS_W'(cur_lin)});
		end
	end

	tcw_screen_ram #(
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
